### src/kdms_pkg.sv
`timescale 1ns / 1ps

package kdms_pkg;

   localparam int unsigned StageWidth = 3;
   localparam int unsigned ValueWidth = 63;
   localparam int unsigned AccWidth   = 64;

   typedef logic [StageWidth-1:0] stage_type;

   // token is: quote s e q quote colon
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_S     = 8'h73;
   localparam logic [7:0] CH_E     = 8'h65;
   localparam logic [7:0] CH_Q     = 8'h71;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;

   localparam stage_type STAGE_IDLE   = 3'd0;
   localparam stage_type STAGE_QUOTE  = 3'd1;
   localparam stage_type STAGE_S      = 3'd2;
   localparam stage_type STAGE_E      = 3'd3;
   localparam stage_type STAGE_Q      = 3'd4;
   localparam stage_type STAGE_QUOTE2 = 3'd5;
   localparam stage_type STAGE_DIGITS = 3'd6;

   // One step of the token matcher with naive-search fallback.
   function automatic stage_type match_next(input stage_type stage, input logic [7:0] b);
      stage_type s;
      logic [7:0] want;
      stage_type result;
      s = (stage < STAGE_DIGITS) ? stage : STAGE_IDLE;
      case (s)
         STAGE_IDLE:   want = CH_QUOTE;
         STAGE_QUOTE:  want = CH_S;
         STAGE_S:      want = CH_E;
         STAGE_E:      want = CH_Q;
         STAGE_Q:      want = CH_QUOTE;
         STAGE_QUOTE2: want = CH_COLON;
         default:      want = CH_QUOTE;
      endcase
      if (b == want) begin
         result = s + 3'd1;
      end else if (s == STAGE_QUOTE2 && b == CH_S) begin
         // trailing quote of the partial match restarts the token
         result = STAGE_S;
      end else if (b == CH_QUOTE) begin
         result = STAGE_QUOTE;
      end else begin
         result = STAGE_IDLE;
      end
      return result;
   endfunction

endpackage

### src/keyed_decimal_max_scanner.sv
`timescale 1ns / 1ps

// Scans a byte stream for the token "seq": and keeps the largest decimal
// value (bit 63 clear) that follows such a token.
//
// req channel: one stream byte per beat; req_tlast marks the final byte.
// rsp channel: one beat per stream, issued after the final byte:
//    rsp_tuser = found, rsp_tdata[62:0] = highest value (0 if none found).
//
// Throughput: one byte per cycle while req_tready is high; the matcher step
// and the times-ten add run combinationally between the scan registers.
// Result path: the final byte loads the closing stage, which closes the last
// digit run and compares it with the best value; the output register loads
// that result once it is free.
// A new stream may start in the cycle after the final byte.
// Reset clears the scanner and drops any pending result.
// If the receiver stalls, one finished result waits in the output register
// and a second in the closing stage; once both are full req_tready drops
// for every byte until the output register drains.
module keyed_decimal_max_scanner
   import kdms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // end_of_stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,   // [62:0] highest_value, [63] zero
   output logic        rsp_tuser    // found
);

   stage_type                 stage_ff, stage_in;
   logic [AccWidth-1:0]       acc_ff, acc_in;
   logic                      seen_ff, seen_in;
   logic [ValueWidth-1:0]     best_ff, best_in;
   logic                      bvalid_ff, bvalid_in;

   logic                      fin_valid_ff, fin_valid_in;
   logic [AccWidth-1:0]       fin_acc_ff, fin_acc_in;
   logic                      fin_seen_ff, fin_seen_in;
   logic [ValueWidth-1:0]     fin_best_ff, fin_best_in;
   logic                      fin_bvalid_ff, fin_bvalid_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [ValueWidth-1:0]     rsp_value_ff, rsp_value_in;
   logic                      rsp_found_ff, rsp_found_in;

   logic                      accept;
   logic                      rsp_free;
   logic                      fin_move;
   logic                      is_digit;
   logic [AccWidth-1:0]       acc_ten;
   logic                      run_counts;
   logic                      fin_counts;
   logic                      in_digits;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign fin_move   = fin_valid_ff && rsp_free;
   assign req_tready = !fin_valid_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;
   assign in_digits  = (stage_ff == STAGE_DIGITS);

   always_comb begin
      is_digit = 1'b0;
      if (req_tdata inside {[CH_ZERO:CH_NINE]}) begin
         is_digit = 1'b1;
      end
   end

   // acc * 10 + digit, wrapping at 64 bits
   assign acc_ten = {acc_ff[AccWidth-4:0], 3'b000} + {acc_ff[AccWidth-2:0], 1'b0}
                    + {{(AccWidth-4){1'b0}}, req_tdata[3:0]};

   assign run_counts = seen_ff && !acc_ff[AccWidth-1]
                       && (!bvalid_ff || (acc_ff[ValueWidth-1:0] > best_ff));

   always_comb begin
      stage_in      = stage_ff;
      acc_in        = acc_ff;
      seen_in       = seen_ff;
      best_in       = best_ff;
      bvalid_in     = bvalid_ff;
      fin_acc_in    = fin_acc_ff;
      fin_seen_in   = fin_seen_ff;
      fin_best_in   = fin_best_ff;
      fin_bvalid_in = fin_bvalid_ff;
      if (accept) begin
         if (req_tlast) begin
            // hand the open run and the best so far to the closing stage
            fin_acc_in    = (in_digits && is_digit) ? acc_ten : acc_ff;
            fin_seen_in   = in_digits && (is_digit || seen_ff);
            fin_best_in   = best_ff;
            fin_bvalid_in = bvalid_ff;
            stage_in      = STAGE_IDLE;
            acc_in        = '0;
            seen_in       = 1'b0;
            best_in       = '0;
            bvalid_in     = 1'b0;
         end else if (in_digits) begin
            if (is_digit) begin
               acc_in  = acc_ten;
               seen_in = 1'b1;
            end else begin
               if (run_counts) begin
                  best_in   = acc_ff[ValueWidth-1:0];
                  bvalid_in = 1'b1;
               end
               acc_in   = '0;
               seen_in  = 1'b0;
               stage_in = match_next(STAGE_IDLE, req_tdata);
            end
         end else begin
            stage_in = match_next(stage_ff, req_tdata);
            if (stage_in == STAGE_DIGITS) begin
               acc_in  = '0;
               seen_in = 1'b0;
            end
         end
      end
   end

   assign fin_counts = fin_seen_ff && !fin_acc_ff[AccWidth-1]
                       && (!fin_bvalid_ff || (fin_acc_ff[ValueWidth-1:0] > fin_best_ff));

   always_comb begin
      fin_valid_in = fin_valid_ff && !rsp_free;
      if (accept && req_tlast) begin
         fin_valid_in = 1'b1;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_value_in = rsp_value_ff;
      rsp_found_in = rsp_found_ff;
      if (fin_move) begin
         rsp_valid_in = 1'b1;
         rsp_found_in = fin_counts || fin_bvalid_ff;
         if (fin_counts) begin
            rsp_value_in = fin_acc_ff[ValueWidth-1:0];
         end else if (fin_bvalid_ff) begin
            rsp_value_in = fin_best_ff;
         end else begin
            rsp_value_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff     <= STAGE_IDLE;
         acc_ff       <= '0;
         seen_ff      <= 1'b0;
         best_ff      <= '0;
         bvalid_ff    <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         stage_ff     <= stage_in;
         acc_ff       <= acc_in;
         seen_ff      <= seen_in;
         best_ff      <= best_in;
         bvalid_ff    <= bvalid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_acc_ff    <= fin_acc_in;
      fin_seen_ff   <= fin_seen_in;
      fin_best_ff   <= fin_best_in;
      fin_bvalid_ff <= fin_bvalid_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_found_ff  <= rsp_found_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_value_ff};
   assign rsp_tuser  = rsp_found_ff;

   a_empty_when_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == '0)
      else $error("result without found flag carries a nonzero value");

   a_stream_restart: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> stage_ff == STAGE_IDLE && !bvalid_ff && !seen_ff)
      else $error("scanner state not cleared after final byte");

   a_pending_held: assert property (@(posedge clock) disable iff (reset)
      fin_valid_ff && !rsp_free |=> fin_valid_ff)
      else $error("pending result lost while output stalled");

   a_stage_range: assert property (@(posedge clock) disable iff (reset)
      stage_ff <= STAGE_DIGITS)
      else $error("match stage out of range");

   a_best_top_clear: assert property (@(posedge clock) disable iff (reset)
      !bvalid_ff |-> best_ff == '0)
      else $error("best value set without a valid flag");

endmodule

### dv/keyed_decimal_max_scanner_checker.sv
`timescale 1ns / 1ps

module keyed_decimal_max_scanner_checker
   import kdms_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [63:0] rsp_tdata,
   input  logic        rsp_tuser,
   output int          fail_count,
   output int          awaiting,
   output int          compared
);

   typedef struct packed {
      logic                  found;
      logic [ValueWidth-1:0] value;
   } scan_summary_type;

   scan_summary_type      expected_summaries[$];

   stage_type             token_stage;
   logic [AccWidth-1:0]   run_value;
   logic                  run_open;
   logic [ValueWidth-1:0] best_value;
   logic                  best_ok;
   int                    mismatches;
   int                    compared_n;

   task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
      $display("%0t ns mismatch on %s: expected %0h, got %0h", $time, what, want, got);
      mismatches++;
   endtask

   function automatic void clear_scan();
      token_stage = STAGE_IDLE;
      run_value   = '0;
      run_open    = 1'b0;
      best_value  = '0;
      best_ok     = 1'b0;
   endfunction

   function automatic stage_type token_step(input stage_type stage, input logic [7:0] b);
      stage_type  s;
      logic [7:0] want;
      s = (stage > STAGE_QUOTE2) ? STAGE_IDLE : stage;
      case (s)
         STAGE_QUOTE:  want = CH_S;
         STAGE_S:      want = CH_E;
         STAGE_E:      want = CH_Q;
         STAGE_Q:      want = CH_QUOTE;
         STAGE_QUOTE2: want = CH_COLON;
         default:      want = CH_QUOTE;
      endcase
      if (b == want) return stage_type'(s + 1);
      // the closing quote of a partial token can open a new one
      if (s == STAGE_QUOTE2 && b == CH_S) return STAGE_S;
      return (b == CH_QUOTE) ? STAGE_QUOTE : STAGE_IDLE;
   endfunction

   // a finished run counts only with bit 63 clear; ties keep the old best
   function automatic void close_run();
      if (run_open && !run_value[AccWidth-1] &&
          (!best_ok || run_value[ValueWidth-1:0] > best_value)) begin
         best_value = run_value[ValueWidth-1:0];
         best_ok    = 1'b1;
      end
      run_value = '0;
      run_open  = 1'b0;
   endfunction

   function automatic void scan_byte(input logic [7:0] b, input logic last);
      scan_summary_type summary;
      if (token_stage == STAGE_DIGITS) begin
         if (b >= CH_ZERO && b <= CH_NINE) begin
            run_value = run_value * 64'd10 + (64'(b) - 64'(CH_ZERO));
            run_open  = 1'b1;
         end else begin
            close_run();
            token_stage = token_step(STAGE_IDLE, b);
         end
      end else begin
         token_stage = token_step(token_stage, b);
         if (token_stage == STAGE_DIGITS) begin
            run_value = '0;
            run_open  = 1'b0;
         end
      end
      if (last) begin
         if (token_stage == STAGE_DIGITS) close_run();
         summary.found = best_ok;
         summary.value = best_ok ? best_value : '0;
         expected_summaries.push_back(summary);
         clear_scan();
      end
   endfunction

   always @(posedge clock) begin
      scan_summary_type want;
      if (reset) begin
         clear_scan();
         expected_summaries.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_summaries.size() == 0) begin
               report("result beat with no stream pending", 64'd0, rsp_tdata);
            end else begin
               want = expected_summaries.pop_front();
               compared_n++;
               if (rsp_tuser !== want.found)
                  report("found", 64'(want.found), 64'(rsp_tuser));
               if (rsp_tdata[ValueWidth-1:0] !== want.value)
                  report("highest_value", 64'(want.value), 64'(rsp_tdata[ValueWidth-1:0]));
               if (rsp_tdata[63] !== 1'b0)
                  report("tdata bit 63", 64'd0, 64'(rsp_tdata[63]));
            end
         end
         if (req_tvalid && req_tready) scan_byte(req_tdata, req_tlast);
      end
      fail_count <= mismatches;
      awaiting   <= expected_summaries.size();
      compared   <= compared_n;
   end

endmodule

### dv/keyed_decimal_max_scanner_tb.sv
`timescale 1ns / 1ps

module keyed_decimal_max_scanner_tb
   import kdms_pkg::*;
();

   localparam int HoldCycles = 300;
   localparam int ByteTarget = 1130;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] data_byte
   logic        req_tlast;   // end_of_stream
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;   // [62:0] highest_value, [63] zero
   logic        rsp_tuser;   // found

   int          fail_count;
   int          awaiting;
   int          compared;

   logic        calm;
   logic        hold_request;
   int          bytes_sent;
   int          streams_sent;
   int          held_cycles;

   logic [7:0]  stream_bytes[$];
   logic [7:0]  last_run[$];

   keyed_decimal_max_scanner u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   keyed_decimal_max_scanner_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .fail_count (fail_count),
      .awaiting   (awaiting),
      .compared   (compared)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("timeout: stream summaries still outstanding");
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random backpressure, one long hold-off when asked
   initial begin
      rsp_tready  = 1'b0;
      held_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_request && held_cycles == 0) begin
            rsp_tready <= 1'b0;
            repeat (HoldCycles) begin
               @(posedge clock);
               held_cycles++;
            end
         end
         if (calm) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(99) >= 22);
      end
   end

   function automatic void put_text(input string s);
      for (int i = 0; i < s.len(); i++) stream_bytes.push_back(s[i]);
   endfunction

   function automatic void put_terminator();
      logic [7:0] b;
      if ($urandom_range(4) == 0) begin
         b = CH_QUOTE;
      end else begin
         do b = 8'($urandom_range(255)); while (b >= CH_ZERO && b <= CH_NINE);
      end
      stream_bytes.push_back(b);
   endfunction

   // digit run: mostly short, some near or past the 63/64-bit limits
   function automatic void put_digits();
      int pick;
      int n;
      pick = $urandom_range(99);
      if (pick < 10 && last_run.size() != 0) begin
         foreach (last_run[i]) stream_bytes.push_back(last_run[i]);
      end else if (pick < 15) begin
         put_text("9223372036854775807");
      end else if (pick < 20) begin
         put_text("9223372036854775808");
      end else if (pick < 25) begin
         put_text("18446744073709551615");
      end else begin
         if (pick < 35) n = 19;
         else if (pick < 43) n = $urandom_range(20, 24);
         else n = $urandom_range(1, 6);
         last_run.delete();
         repeat (n) last_run.push_back(8'(CH_ZERO + $urandom_range(9)));
         foreach (last_run[i]) stream_bytes.push_back(last_run[i]);
      end
   endfunction

   function automatic void build_random_stream();
      string token;
      int    segs;
      int    kind;
      int    n;
      token = "\"seq\":";
      stream_bytes.delete();
      segs = $urandom_range(1, 3);
      for (int s = 0; s < segs; s++) begin
         kind = $urandom_range(99);
         if (kind < 60) begin
            if (kind < 48) put_text(token);
            else put_text("\"seq\"seq\":");
            put_digits();
            // leaving the run open lets the final byte close it
            if (s != segs - 1 || $urandom_range(1) == 0) put_terminator();
         end else if (kind < 70) begin
            put_text(token);
            put_terminator();
         end else if (kind < 82) begin
            n = $urandom_range(1, 5);
            for (int i = 0; i < n; i++) stream_bytes.push_back(token[i]);
            stream_bytes.push_back(8'($urandom_range(255)));
         end else begin
            repeat ($urandom_range(1, 8)) stream_bytes.push_back(8'($urandom_range(255)));
         end
      end
   endfunction

   task automatic send_beat(input logic [7:0] b, input logic last);
      if (!calm) begin
         while ($urandom_range(99) < 22) begin
            req_tvalid <= 1'b0;
            req_tdata  <= 8'($urandom);
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= last;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_stream();
      for (int i = 0; i < stream_bytes.size(); i++)
         send_beat(stream_bytes[i], i == stream_bytes.size() - 1);
      streams_sent++;
   endtask

   initial begin
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = 8'h00;
      req_tlast    = 1'b0;
      calm         = 1'b0;
      hold_request = 1'b0;
      bytes_sent   = 0;
      streams_sent = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // single zero byte, no token
      stream_bytes.delete();
      stream_bytes.push_back(8'h00);
      send_stream();
      // token with no digits, run closed by a quote that re-enters the
      // matcher, fallback after quote-seq-quote, tie, stream ending in a run
      stream_bytes.delete();
      put_text("\"seq\":\"seq\":42\"seq\"seq\":42");
      send_stream();
      stream_bytes.delete();
      stream_bytes.push_back(8'hFF);
      send_stream();

      while (bytes_sent < 380) begin
         build_random_stream();
         send_stream();
      end

      calm <= 1'b1;
      while (bytes_sent < 640) begin
         build_random_stream();
         send_stream();
      end
      calm <= 1'b0;

      // short streams against a stalled receiver fill the output side
      hold_request <= 1'b1;
      repeat (16) begin
         stream_bytes.delete();
         if ($urandom_range(1) == 0) begin
            put_text("\"seq\":");
            stream_bytes.push_back(8'(CH_ZERO + $urandom_range(9)));
         end else begin
            stream_bytes.push_back(8'($urandom_range(255)));
         end
         send_stream();
      end

      while (bytes_sent < ByteTarget) begin
         build_random_stream();
         send_stream();
      end
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;

      @(posedge clock);
      while (awaiting != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("scanned %0d bytes in %0d streams, %0d summaries compared",
               bytes_sent, streams_sent, compared);
      $display("included a %0d-cycle receiver hold-off and a no-idle stretch", held_cycles);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
